// ----- design/ubxfr_pkg.sv -----
// Shared constants and types for the UBX frame receiver.
`default_nettype none
package ubxfr_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;

  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  localparam logic [1:0] REG_MESSAGE_CLASS  = 2'd0;
  localparam logic [1:0] REG_MESSAGE_ID     = 2'd1;
  localparam logic [1:0] REG_PAYLOAD_LENGTH = 2'd2;

  localparam logic [7:0]  RST_MESSAGE_CLASS  = 8'h01;
  localparam logic [7:0]  RST_MESSAGE_ID     = 8'h07;
  localparam logic [15:0] RST_PAYLOAD_LENGTH = 16'd92;

  typedef struct packed {
    logic [7:0]  message_class;
    logic [7:0]  message_id;
    logic [15:0] payload_length;
  } cfg_t;

endpackage
`default_nettype wire

// ----- design/ubxfr_cfg_regs.sv -----
// APB configuration registers: message class, message ID and payload length.
`default_nettype none
module ubxfr_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ubxfr_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [ubxfr_pkg::DATA_W-1:0]  pwdata,
  output logic      [ubxfr_pkg::DATA_W-1:0]  prdata,
  output logic                               pready,
  output ubxfr_pkg::cfg_t                    cfg
);

  ubxfr_pkg::cfg_t cfg_r;
  ubxfr_pkg::cfg_t cfg_nxt;
  logic            wr_en;
  logic [1:0]      reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[ubxfr_pkg::ADDR_W-1:2];
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        ubxfr_pkg::REG_MESSAGE_CLASS:  cfg_nxt.message_class  = pwdata[7:0];
        ubxfr_pkg::REG_MESSAGE_ID:     cfg_nxt.message_id     = pwdata[7:0];
        ubxfr_pkg::REG_PAYLOAD_LENGTH: cfg_nxt.payload_length = pwdata[15:0];
        default:                       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      ubxfr_pkg::REG_MESSAGE_CLASS:  prdata = {24'd0, cfg_r.message_class};
      ubxfr_pkg::REG_MESSAGE_ID:     prdata = {24'd0, cfg_r.message_id};
      ubxfr_pkg::REG_PAYLOAD_LENGTH: prdata = {16'd0, cfg_r.payload_length};
      default:                       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.message_class  <= ubxfr_pkg::RST_MESSAGE_CLASS;
      cfg_r.message_id     <= ubxfr_pkg::RST_MESSAGE_ID;
      cfg_r.payload_length <= ubxfr_pkg::RST_PAYLOAD_LENGTH;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- design/ubx_frame_receiver.sv -----
// UBX frame receiver: sync hunt, header check, Fletcher-8 checksum, payload output.
//
// Input channel (in_valid/in_ready/in_rx_byte) takes one raw receiver byte per
// request. The block hunts for the sync pair B5 62, checks class, ID and the
// little-endian length against the configured registers and runs the 8-bit
// Fletcher checksum over header and payload.
// Output channel (out_valid/out_ready) carries one request per payload byte
// with its offset, and one end request after the two checksum bytes with
// out_checksum_good set when both checksum bytes matched.
// A result is registered and appears at the output in the cycle after its input
// byte is accepted. Throughput: one byte per cycle while the output is not stalled;
// the per-byte state update is a single register stage behind the input handshake.
// The output register drains while the next byte is taken; in_ready drops only
// when a result is held and out_ready is low, so a stalled receiver stalls
// the input one-for-one without losing results.
// Reset (rst_n, synchronous) returns the parser to hunting, empties the
// output register and loads class 0x01, ID 0x07, length 92.
// Registers over APB at byte addresses 0x0, 0x4, 0x8; write only while idle.
`default_nettype none
module ubx_frame_receiver (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [7:0]                    in_rx_byte,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_is_end,
  output logic      [7:0]                    out_payload_byte,
  output logic      [15:0]                   out_byte_offset,
  output logic                               out_checksum_good,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ubxfr_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [ubxfr_pkg::DATA_W-1:0]  pwdata,
  output logic      [ubxfr_pkg::DATA_W-1:0]  prdata,
  output logic                               pready
);

  typedef enum logic [3:0] {
    PH_HUNT1, PH_HUNT2, PH_CLASS, PH_ID, PH_LEN_LO,
    PH_LEN_HI, PH_PAYLOAD, PH_CK_A, PH_CK_B
  } phase_t;

  ubxfr_pkg::cfg_t cfg;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  sum_a_r, sum_a_nxt;
  logic [7:0]  sum_b_r, sum_b_nxt;
  logic [15:0] count_r, count_nxt;
  logic [7:0]  len_lo_r, len_lo_nxt;
  logic        ck_a_ok_r, ck_a_ok_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic        out_is_end_r, out_is_end_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic [15:0] out_offset_r, out_offset_nxt;
  logic        out_good_r, out_good_nxt;

  logic        accept;
  logic        emit;
  logic [7:0]  add_a;
  logic [7:0]  add_b;
  logic [15:0] count_inc;
  phase_t      reject_phase;

  ubxfr_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign add_a        = sum_a_r + in_rx_byte;
  assign add_b        = sum_b_r + add_a;
  assign count_inc    = (count_r != 16'hFFFF) ? count_r + 16'd1 : count_r;
  assign reject_phase = (in_rx_byte == ubxfr_pkg::SYNC_FIRST) ? PH_HUNT2 : PH_HUNT1;

  always_comb begin
    phase_nxt   = phase_r;
    sum_a_nxt   = sum_a_r;
    sum_b_nxt   = sum_b_r;
    count_nxt   = count_r;
    len_lo_nxt  = len_lo_r;
    ck_a_ok_nxt = ck_a_ok_r;
    emit           = 1'b0;
    out_is_end_nxt = 1'b0;
    out_byte_nxt   = 8'd0;
    out_offset_nxt = count_r;
    out_good_nxt   = 1'b0;
    unique case (phase_r)
      PH_HUNT1: begin
        phase_nxt = reject_phase;
      end
      PH_HUNT2: begin
        if (in_rx_byte == ubxfr_pkg::SYNC_SECOND) begin
          phase_nxt   = PH_CLASS;
          sum_a_nxt   = 8'd0;
          sum_b_nxt   = 8'd0;
          count_nxt   = 16'd0;
          ck_a_ok_nxt = 1'b0;
        end else begin
          phase_nxt = reject_phase;
        end
      end
      PH_CLASS: begin
        if (in_rx_byte == cfg.message_class) begin
          sum_a_nxt = add_a;
          sum_b_nxt = add_b;
          phase_nxt = PH_ID;
        end else begin
          phase_nxt = reject_phase;
        end
      end
      PH_ID: begin
        if (in_rx_byte == cfg.message_id) begin
          sum_a_nxt = add_a;
          sum_b_nxt = add_b;
          phase_nxt = PH_LEN_LO;
        end else begin
          phase_nxt = reject_phase;
        end
      end
      PH_LEN_LO: begin
        len_lo_nxt = in_rx_byte;
        sum_a_nxt  = add_a;
        sum_b_nxt  = add_b;
        phase_nxt  = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        if ({in_rx_byte, len_lo_r} == cfg.payload_length) begin
          sum_a_nxt = add_a;
          sum_b_nxt = add_b;
          count_nxt = 16'd0;
          phase_nxt = (cfg.payload_length == 16'd0) ? PH_CK_A : PH_PAYLOAD;
        end else begin
          phase_nxt = reject_phase;
        end
      end
      PH_PAYLOAD: begin
        sum_a_nxt    = add_a;
        sum_b_nxt    = add_b;
        emit         = 1'b1;
        out_byte_nxt = in_rx_byte;
        count_nxt    = count_inc;
        if (count_inc >= cfg.payload_length) begin
          phase_nxt = PH_CK_A;
        end
      end
      PH_CK_A: begin
        ck_a_ok_nxt = (in_rx_byte == sum_a_r);
        phase_nxt   = PH_CK_B;
      end
      PH_CK_B: begin
        emit           = 1'b1;
        out_is_end_nxt = 1'b1;
        out_good_nxt   = ck_a_ok_r && (in_rx_byte == sum_b_r);
        phase_nxt      = PH_HUNT1;
      end
      default: begin
        phase_nxt = PH_HUNT1;
      end
    endcase
  end

  always_comb begin
    if (accept && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HUNT1;
      sum_a_r      <= 8'd0;
      sum_b_r      <= 8'd0;
      count_r      <= 16'd0;
      len_lo_r     <= 8'd0;
      ck_a_ok_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      out_is_end_r <= 1'b0;
      out_byte_r   <= 8'd0;
      out_offset_r <= 16'd0;
      out_good_r   <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        phase_r   <= phase_nxt;
        sum_a_r   <= sum_a_nxt;
        sum_b_r   <= sum_b_nxt;
        count_r   <= count_nxt;
        len_lo_r  <= len_lo_nxt;
        ck_a_ok_r <= ck_a_ok_nxt;
      end
      if (accept && emit) begin
        out_is_end_r <= out_is_end_nxt;
        out_byte_r   <= out_byte_nxt;
        out_offset_r <= out_offset_nxt;
        out_good_r   <= out_good_nxt;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_is_end        = out_is_end_r;
  assign out_payload_byte  = out_byte_r;
  assign out_byte_offset   = out_offset_r;
  assign out_checksum_good = out_good_r;

endmodule
`default_nettype wire
